// ===== hw/rtl/rgf_pkg.sv =====
// Shared types and constants for the rounded gradient rectangle fill block.
// Payload structs, the pipeline stage record, register map and screen geometry.
// No dependencies.
package rgf_pkg;

  // Screen geometry and framebuffer row stride
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int ROW_STRIDE    = 1024;

  // Pipeline depth: setup, product, eight quotient bits, color assembly
  localparam int NUM_STAGES = 11;
  localparam int DIV_FIRST  = 2;
  localparam int DIV_BITS   = 8;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_RECT_LEFT   = 3'd0;
  localparam logic [2:0] REG_RECT_TOP    = 3'd1;
  localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CORNER_RAD  = 3'd4;
  localparam logic [2:0] REG_COLOR_START = 3'd5;
  localparam logic [2:0] REG_COLOR_END   = 3'd6;
  localparam logic [2:0] REG_GRAD_HORIZ  = 3'd7;

  typedef struct packed {
    logic [11:0] col_index;
    logic [11:0] row_index;
  } pix_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [19:0] pixel_address;
    logic [23:0] pixel_color;
  } pix_out_t;

  // One record per pipeline stage; each stage fills the fields it owns
  typedef struct packed {
    logic                in_rng;
    logic                flat;
    logic                on_scr;
    logic                dx_pos;
    logic                dy_pos;
    logic                corner_out;
    logic [11:0]         col;
    logic [11:0]         row;
    logic [11:0]         t;
    logic [11:0]         span;
    logic [10:0]         rad;
    logic [10:0]         dx;
    logic [10:0]         dy;
    logic signed [13:0]  sx;
    logic signed [13:0]  sy;
    logic [21:0]         dsq_x;
    logic [21:0]         dsq_y;
    logic [21:0]         rsq;
    logic [19:0]         addr;
    logic [2:0]          neg;
    logic [2:0][19:0]    rem;
    logic [2:0][7:0]     quo;
    pix_out_t            res;
  } rgf_pipe_t;

  // Distance of a coordinate into the corner band, zero in the straight part
  function automatic logic signed [13:0] corner_dist(input logic [11:0] p,
                                                     input logic [11:0] ext,
                                                     input logic [10:0] r);
    logic signed [13:0] ps;
    logic signed [13:0] es;
    logic signed [13:0] rs;
    ps = $signed({2'b00, p});
    es = $signed({2'b00, ext});
    rs = $signed({3'b000, r});
    if (ps < rs) begin
      return rs - ps;
    end else if (ps >= es - rs) begin
      return ps - (es - rs - 14'sd1);
    end else begin
      return 14'sd0;
    end
  endfunction

endpackage

// ===== hw/rtl/rounded_gradient_rect_fill_top.sv =====
// The pipeline has 11 register stages. Throughput: one pixel per cycle while
// res_stall is low; each channel divide resolves one quotient bit per stage
// over eight stages, so nothing iterates.
// Reset (rst, synchronous): clears all stage valid bits and sets every
// configuration register to zero. No clearing pass. Depends on rgf_pkg.
module rounded_gradient_rect_fill_top #(
  parameter int SCREEN_WIDTH  = rgf_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = rgf_pkg::SCREEN_HEIGHT,
  parameter int ROW_STRIDE    = rgf_pkg::ROW_STRIDE
) (
  input  logic             clk,
  input  logic             rst,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // pixel coordinates
  input  logic             pix_valid,
  output logic             pix_stall,
  input  rgf_pkg::pix_in_t pix,
  // shaded pixels
  output logic             res_valid,
  input  logic             res_stall,
  output rgf_pkg::pix_out_t res
);
  import rgf_pkg::*;

  // Configuration registers
  logic signed [12:0] rect_left;
  logic signed [12:0] rect_top;
  logic [11:0]        rect_width;
  logic [11:0]        rect_height;
  logic [10:0]        corner_radius;
  logic [23:0]        color_start;
  logic [23:0]        color_end;
  logic               gradient_horizontal;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left           <= '0;
      rect_top            <= '0;
      rect_width          <= '0;
      rect_height         <= '0;
      corner_radius       <= '0;
      color_start         <= '0;
      color_end           <= '0;
      gradient_horizontal <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RECT_LEFT:   rect_left           <= $signed(pwdata[12:0]);
        REG_RECT_TOP:    rect_top            <= $signed(pwdata[12:0]);
        REG_RECT_WIDTH:  rect_width          <= pwdata[11:0];
        REG_RECT_HEIGHT: rect_height         <= pwdata[11:0];
        REG_CORNER_RAD:  corner_radius       <= pwdata[10:0];
        REG_COLOR_START: color_start         <= pwdata[23:0];
        REG_COLOR_END:   color_end           <= pwdata[23:0];
        REG_GRAD_HORIZ:  gradient_horizontal <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads; signed fields come back sign extended
  always_comb begin
    case (reg_idx)
      REG_RECT_LEFT:   prdata = 32'(signed'(rect_left));
      REG_RECT_TOP:    prdata = 32'(signed'(rect_top));
      REG_RECT_WIDTH:  prdata = 32'(rect_width);
      REG_RECT_HEIGHT: prdata = 32'(rect_height);
      REG_CORNER_RAD:  prdata = 32'(corner_radius);
      REG_COLOR_START: prdata = 32'(color_start);
      REG_COLOR_END:   prdata = 32'(color_end);
      REG_GRAD_HORIZ:  prdata = 32'(gradient_horizontal);
      default:         prdata = '0;
    endcase
  end

  // Pipeline registers and per-stage flow control
  rgf_pipe_t                stg  [NUM_STAGES];
  rgf_pipe_t                nxt  [NUM_STAGES];
  logic [NUM_STAGES-1:0]    vld;
  logic [NUM_STAGES-1:0]    rdy;

  // A stage takes new data when it is empty or the next stage moves
  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !res_stall;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign pix_stall = !rdy[0];
  assign res_valid = vld[NUM_STAGES-1];
  assign res       = stg[NUM_STAGES-1].res;

  // Stage setup temporaries
  logic [10:0]        half_w;
  logic [10:0]        half_h;
  logic [10:0]        rad_w;
  logic [11:0]        ext;
  logic signed [13:0] cdx;
  logic signed [13:0] cdy;
  logic [7:0]         ch_a;
  logic [7:0]         ch_b;
  logic [7:0]         ch_mag;
  logic [23:0]        mixed;
  logic [19:0]        dshift;

  always_comb begin
    // default: carry the record forward
    nxt[0] = '0;
    for (int s = 1; s < NUM_STAGES; s++) begin
      nxt[s] = stg[s-1];
    end

    // Stage 0: range check, radius clamp, gradient axis, screen coordinates
    half_w = rect_width[11:1];
    half_h = rect_height[11:1];
    rad_w  = (corner_radius > half_w) ? half_w : corner_radius;
    ext    = gradient_horizontal ? rect_width : rect_height;
    nxt[0].in_rng = (pix.col_index < rect_width) && (pix.row_index < rect_height);
    nxt[0].rad    = (rad_w > half_h) ? half_h : rad_w;
    nxt[0].col    = pix.col_index;
    nxt[0].row    = pix.row_index;
    nxt[0].t      = gradient_horizontal ? pix.col_index : pix.row_index;
    nxt[0].flat   = (ext[11:1] == 11'd0);
    nxt[0].span   = ext - 12'd1;
    nxt[0].sx     = $signed({rect_left[12], rect_left}) + $signed({2'b00, pix.col_index});
    nxt[0].sy     = $signed({rect_top[12], rect_top}) + $signed({2'b00, pix.row_index});

    // Stage 1: corner distances, channel products, screen clip, row offset
    cdx = corner_dist(stg[0].col, rect_width, stg[0].rad);
    cdy = corner_dist(stg[0].row, rect_height, stg[0].rad);
    nxt[1].dx_pos = (cdx > 14'sd0);
    nxt[1].dy_pos = (cdy > 14'sd0);
    nxt[1].dx     = cdx[10:0];
    nxt[1].dy     = cdy[10:0];
    nxt[1].on_scr = (stg[0].sx >= 14'sd0) && (stg[0].sx < $signed(14'(SCREEN_WIDTH))) &&
                    (stg[0].sy >= 14'sd0) && (stg[0].sy < $signed(14'(SCREEN_HEIGHT)));
    nxt[1].addr   = 20'(25'(stg[0].sy[11:0]) * 25'(ROW_STRIDE));
    for (int c = 0; c < 3; c++) begin
      ch_a   = color_start[8*c +: 8];
      ch_b   = color_end[8*c +: 8];
      ch_mag = (ch_b < ch_a) ? (ch_a - ch_b) : (ch_b - ch_a);
      nxt[1].neg[c] = (ch_b < ch_a);
      nxt[1].rem[c] = 20'(ch_mag) * 20'(stg[0].t);
      nxt[1].quo[c] = '0;
    end

    // Stage 2: squares for the corner test, final address
    nxt[2].dsq_x = 22'(stg[1].dx) * 22'(stg[1].dx);
    nxt[2].dsq_y = 22'(stg[1].dy) * 22'(stg[1].dy);
    nxt[2].rsq   = 22'(stg[1].rad) * 22'(stg[1].rad);
    nxt[2].addr  = stg[1].addr + 20'(stg[1].sx[11:0]);

    // Stage 3: corner circle test
    nxt[3].corner_out = stg[2].dx_pos && stg[2].dy_pos &&
                        (({1'b0, stg[2].dsq_x} + {1'b0, stg[2].dsq_y}) > {1'b0, stg[2].rsq});

    // Stages 2..9: restoring divide, one quotient bit per stage, MSB first
    for (int s = DIV_FIRST; s < DIV_FIRST + DIV_BITS; s++) begin
      for (int c = 0; c < 3; c++) begin
        dshift = 20'(stg[s-1].span) << (DIV_FIRST + DIV_BITS - 1 - s);
        if (stg[s-1].rem[c] >= dshift) begin
          nxt[s].rem[c] = stg[s-1].rem[c] - dshift;
          nxt[s].quo[c][DIV_FIRST + DIV_BITS - 1 - s] = 1'b1;
        end
      end
    end

    // Stage 10: apply quotient to start color, mask and clip
    for (int c = 0; c < 3; c++) begin
      ch_a = color_start[8*c +: 8];
      mixed[8*c +: 8] = stg[NUM_STAGES-2].neg[c] ? (ch_a - stg[NUM_STAGES-2].quo[c])
                                                : (ch_a + stg[NUM_STAGES-2].quo[c]);
    end
    if (stg[NUM_STAGES-2].flat) begin
      mixed = color_start;
    end
    nxt[NUM_STAGES-1].res.write_enable  = stg[NUM_STAGES-2].in_rng &&
                                          !stg[NUM_STAGES-2].corner_out &&
                                          stg[NUM_STAGES-2].on_scr;
    nxt[NUM_STAGES-1].res.pixel_address = nxt[NUM_STAGES-1].res.write_enable ?
                                          stg[NUM_STAGES-2].addr : 20'd0;
    nxt[NUM_STAGES-1].res.pixel_color   = stg[NUM_STAGES-2].in_rng ? mixed : 24'd0;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pix_valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (rdy[s]) begin
        stg[s] <= nxt[s];
      end
    end
  end

endmodule

// ===== dv/rgf_checker.sv =====
`timescale 1ns / 1ps
// Pixel checker for rounded_gradient_rect_fill_top: shadows the register writes,
// predicts each shaded pixel and compares it with the block's output. Depends on rgf_pkg.
module rgf_checker
  import rgf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        pix_valid,
  input  logic        pix_stall,
  input  pix_in_t     pix,
  input  logic        res_valid,
  input  logic        res_stall,
  input  pix_out_t    res,
  output int          errors,
  output int          pending
);

  // shadow copy of the register file
  int          left_q;
  int          top_q;
  int          width_q;
  int          height_q;
  int          radius_q;
  logic [23:0] start_q;
  logic [23:0] end_q;
  logic        horiz_q;

  pix_out_t pending_pixels[$];

  // per-channel linear blend, truncating toward zero
  function automatic logic [23:0] blend_color(input int t, input int span);
    logic [23:0] c;
    int a;
    int b;
    int v;
    if (span <= 0) return start_q;
    for (int k = 0; k < 3; k++) begin
      a = int'(start_q[8*k +: 8]);
      b = int'(end_q[8*k +: 8]);
      v = a + ((b - a) * t) / span;
      c[8*k +: 8] = v[7:0];
    end
    return c;
  endfunction

  // depth into the corner band along one axis, zero on the straight part
  function automatic int band_depth(input int p, input int ext, input int r);
    if (p < r) return r - p;
    if (p >= ext - r) return p - (ext - r - 1);
    return 0;
  endfunction

  function automatic pix_out_t shade_pixel(input pix_in_t p);
    pix_out_t o;
    int i;
    int j;
    int r;
    int dx;
    int dy;
    int sx;
    int sy;
    logic on;
    o = '0;
    i = int'(p.col_index);
    j = int'(p.row_index);
    if (i >= width_q || j >= height_q) return o;
    r = radius_q;
    if (r * 2 > width_q) r = width_q / 2;
    if (r * 2 > height_q) r = height_q / 2;
    if (horiz_q) o.pixel_color = blend_color(i, width_q - 1);
    else o.pixel_color = blend_color(j, height_q - 1);
    on = 1'b1;
    dx = band_depth(i, width_q, r);
    dy = band_depth(j, height_q, r);
    if (dx > 0 && dy > 0 && dx * dx + dy * dy > r * r) on = 1'b0;
    sx = left_q + i;
    sy = top_q + j;
    if (sx < 0 || sx >= SCREEN_WIDTH || sy < 0 || sy >= SCREEN_HEIGHT) on = 1'b0;
    if (on) begin
      o.write_enable  = 1'b1;
      o.pixel_address = 20'(sy * ROW_STRIDE + sx);
    end
    return o;
  endfunction

  // register shadow, prediction on input transfers, compare on output transfers
  always @(posedge clk) begin
    pix_out_t want;
    if (rst) begin
      left_q   = 0;
      top_q    = 0;
      width_q  = 0;
      height_q = 0;
      radius_q = 0;
      start_q  = '0;
      end_q    = '0;
      horiz_q  = 1'b0;
      pending_pixels.delete();
      pending  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_RECT_LEFT:   left_q   = int'($signed(pwdata[12:0]));
          REG_RECT_TOP:    top_q    = int'($signed(pwdata[12:0]));
          REG_RECT_WIDTH:  width_q  = int'(pwdata[11:0]);
          REG_RECT_HEIGHT: height_q = int'(pwdata[11:0]);
          REG_CORNER_RAD:  radius_q = int'(pwdata[10:0]);
          REG_COLOR_START: start_q  = pwdata[23:0];
          REG_COLOR_END:   end_q    = pwdata[23:0];
          REG_GRAD_HORIZ:  horiz_q  = pwdata[0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (pending_pixels.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected pixel we=%0b addr=%h color=%h", $realtime,
                     res.write_enable, res.pixel_address, res.pixel_color);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (want.write_enable !== res.write_enable ||
              want.pixel_address !== res.pixel_address ||
              want.pixel_color !== res.pixel_color) begin
            if (errors < 10)
              $display("%0t: pixel mismatch exp we=%0b addr=%h color=%h got we=%0b addr=%h color=%h",
                       $realtime, want.write_enable, want.pixel_address, want.pixel_color,
                       res.write_enable, res.pixel_address, res.pixel_color);
            errors++;
          end
        end
      end
      if (pix_valid && !pix_stall) pending_pixels.push_back(shade_pixel(pix));
      pending = pending_pixels.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for rounded_gradient_rect_fill_top: directed and random rectangles,
// random idling on both channels. Depends on rgf_pkg, the block and rgf_checker.
module testbench;
  import rgf_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        pix_valid;
  logic        pix_stall;
  pix_in_t     pix;
  logic        res_valid;
  logic        res_stall;
  pix_out_t    res;

  int errors;
  int pending;
  bit idle_on;

  rounded_gradient_rect_fill_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  rgf_checker shade_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver backpressure in random bursts
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // keep the value bits, optionally fill the unused upper bits with noise
  function automatic logic [31:0] pad(input logic [31:0] v, input int width, input bit junk);
    logic [31:0] m;
    m = (32'h1 << width) - 32'h1;
    return (v & m) | (junk ? ($urandom() & ~m) : 32'h0);
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one pixel transfer, with an optional idle gap before it
  task automatic send_pix(input logic [11:0] c, input logic [11:0] r);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      pix_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    pix       <= {c, r};
    do @(posedge clk); while (pix_stall);
  endtask

  // stop sending and wait for every predicted pixel to come out
  task automatic drain();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (NUM_STAGES + 2) @(negedge clk);
  endtask

  task automatic set_rect(input int left, input int top, input int w, input int h,
                          input int rad, input logic [23:0] cs, input logic [23:0] ce,
                          input bit hz, input bit junk);
    drain();
    cfg_write(REG_RECT_LEFT,   pad(left, 13, junk));
    cfg_write(REG_RECT_TOP,    pad(top, 13, junk));
    cfg_write(REG_RECT_WIDTH,  pad(w, 12, junk));
    cfg_write(REG_RECT_HEIGHT, pad(h, 12, junk));
    cfg_write(REG_CORNER_RAD,  pad(rad, 11, junk));
    cfg_write(REG_COLOR_START, pad(32'(cs), 24, junk));
    cfg_write(REG_COLOR_END,   pad(32'(ce), 24, junk));
    cfg_write(REG_GRAD_HORIZ,  pad(32'(hz), 1, junk));
  endtask

  // pick an extent: mostly small, sometimes zero, full or anything
  function automatic int pick_extent();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 4095;
      2:       return $urandom_range(1, 4095);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  // pick an origin, often near a screen edge so clipping is exercised
  function automatic int pick_origin(input int screen);
    case ($urandom_range(0, 4))
      0:       return int'($urandom_range(0, 8191)) - 4096;
      1:       return int'($urandom_range(0, 80)) - 40;
      2:       return screen - int'($urandom_range(0, 40));
      default: return $urandom_range(0, screen - 1);
    endcase
  endfunction

  initial begin
    int w;
    int h;
    int rad;
    int n;
    logic [23:0] cs;
    logic [23:0] ce;

    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    pix_valid = 1'b0;
    pix       = '0;
    idle_on   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: zero-size rectangle, everything out of range
    send_pix(12'd0, 12'd0);
    send_pix(12'hFFF, 12'hFFF);

    // small rectangle, full black to white vertical gradient, rounded corners
    set_rect(10, 20, 16, 12, 5, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0);
    send_pix(12'd0, 12'd0);
    send_pix(12'd15, 12'd11);
    send_pix(12'd0, 12'd5);
    send_pix(12'd7, 12'd0);
    send_pix(12'd16, 12'd0);
    send_pix(12'd0, 12'd12);

    // largest rectangle and radius, horizontal gradient, mostly off screen
    set_rect(1000, 760, 4095, 4095, 2047, 24'hFF00FF, 24'h00FF00, 1'b1, 1'b0);
    send_pix(12'd4094, 12'd4094);
    send_pix(12'd0, 12'd0);
    send_pix(12'd2047, 12'd2047);
    send_pix(12'd23, 12'd7);
    send_pix(12'hFFF, 12'd0);

    // one-pixel extent gives the start colour
    set_rect(-4096, 4095, 1, 1, 2047, 24'h123456, 24'hABCDEF, 1'b0, 1'b0);
    send_pix(12'd0, 12'd0);
    set_rect(4095, -4096, 1, 1, 0, 24'h123456, 24'hABCDEF, 1'b1, 1'b0);
    send_pix(12'd0, 12'd0);

    // flat fill, partly left of and above the screen
    set_rect(-5, -3, 200, 3, 0, 24'h5A5A5A, 24'h5A5A5A, 1'b0, 1'b0);
    send_pix(12'd0, 12'd0);
    send_pix(12'd5, 12'd3);
    send_pix(12'd5, 12'd2);
    send_pix(12'd199, 12'd2);

    // whole screen, falling horizontal gradient, address extremes
    set_rect(0, 0, 1024, 768, 0, 24'hFFFFFF, 24'h000000, 1'b1, 1'b0);
    send_pix(12'd1023, 12'd767);
    send_pix(12'd0, 12'd0);
    send_pix(12'd512, 12'd384);

    // random rectangles; the last phases run without idling
    for (int ph = 0; ph < 23; ph++) begin
      w   = pick_extent();
      h   = pick_extent();
      case ($urandom_range(0, 3))
        0:       rad = 2047;
        1:       rad = 0;
        2:       rad = $urandom_range(0, 2047);
        default: rad = $urandom_range(0, 40);
      endcase
      cs = 24'($urandom());
      case ($urandom_range(0, 4))
        0:       ce = cs;
        1:       begin cs = 24'h000000; ce = 24'hFFFFFF; end
        default: ce = 24'($urandom());
      endcase
      set_rect(pick_origin(SCREEN_WIDTH), pick_origin(SCREEN_HEIGHT), w, h, rad, cs, ce,
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      idle_on <= (ph < 20) && ($urandom_range(0, 9) < 7);
      n = 50;
      for (int k = 0; k < n; k++) begin
        if (w > 0 && h > 0 && $urandom_range(0, 7) != 0)
          send_pix(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)));
        else
          send_pix(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        // sender holds off mid-phase until the pipe is empty
        if (ph == 5 && k == n / 2) drain();
      end
    end

    idle_on <= 1'b0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
